@@ hdl/assert_macros.svh @@
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, ignored while reset is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_CLK(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hdl/gfsc_pkg.sv @@
package gfsc_pkg;

   typedef enum logic [1:0] {
      STAGE_UDP0,
      STAGE_UDP1,
      STAGE_FOUND,
      STAGE_EXCLUDED
   } stage_type;

   typedef enum logic [1:0] {
      VERDICT_UNDECIDED,
      VERDICT_FOUND,
      VERDICT_EXCLUDED
   } verdict_type;

   typedef enum logic [1:0] {
      CLS_EXCLUDE,
      CLS_FOUND,
      CLS_UDP
   } class_type;

   typedef enum logic [1:0] {
      SCAN_SEEK,
      SCAN_GAP,
      SCAN_COMPARE,
      SCAN_DONE
   } scan_type;

   typedef struct packed {
      logic [7:0]  flow_slot;
      logic        is_udp;
      logic [15:0] packet_length;
      logic [7:0]  data_byte;
      logic        first_of_packet;
      logic        last_of_packet;
      logic        new_flow;
   } req_type;

   // Work for the back part: an optional stage clear, then an optional classify.
   typedef struct packed {
      logic [7:0] flow_slot;
      logic       clear;
      logic       classify;
      class_type  cls;
      logic       start_ok;
      logic       port_ok;
   } cmd_type;

   typedef struct packed {
      logic [7:0]  flow_slot;
      verdict_type verdict;
   } rsp_type;

   localparam int CMDQ_DEPTH = 4;
   localparam int RSPQ_DEPTH = 2;

   localparam logic [15:0] HEAD_LEN          = 16'd18;
   localparam logic [15:0] TCP_FIXED_LEN     = 16'd1460;
   localparam logic [15:0] TCP_SCAN_MIN_LEN  = 16'd129;
   localparam logic [15:0] TCP_SCAN_BACK     = 16'd112;
   localparam logic [16:0] TCP_SCAN_SPAN     = 17'd32;
   localparam logic [4:0]  SIG_TCP_LEN       = 5'd18;
   localparam logic [7:0]  SIG_LEAD_BYTE     = 8'hf1;
   localparam logic [15:0] UDP_MIN_LEN       = 16'd48;
   localparam logic [15:0] UDP_LEN_HI_POS    = 16'd2;
   localparam logic [15:0] UDP_LEN_LO_POS    = 16'd3;
   localparam logic [15:0] UDP_START_POS     = 16'd28;
   localparam logic [15:0] UDP_START_END     = 16'd40;
   localparam logic [15:0] UDP_PORT_HI_POS   = 16'd18;
   localparam logic [15:0] UDP_PORT_LO_POS   = 16'd19;
   localparam logic [7:0]  UDP_PORT_HI       = 8'h07;
   localparam logic [7:0]  UDP_PORT_LO       = 8'hd7;

   function automatic logic head_checked(logic [4:0] i);
      return (i <= 5'd5) || (i == 5'd10) || (i == 5'd11) || (i == 5'd16) || (i == 5'd17);
   endfunction

   function automatic logic [7:0] head_byte(logic [4:0] i);
      logic [7:0] b;
      case (i)
         5'd0:    b = 8'hf1;
         5'd1:    b = 8'ha0;
         5'd2:    b = 8'h06;
         5'd3:    b = 8'h01;
         5'd11:   b = 8'h01;
         5'd17:   b = 8'h70;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic [7:0] sig_tcp_byte(logic [4:0] i);
      logic [7:0] b;
      case (i)
         5'd0:    b = 8'h39;
         5'd1:    b = 8'h33;
         5'd2:    b = 8'h37;
         5'd3:    b = 8'h61;
         5'd4:    b = 8'h61;
         5'd5:    b = 8'h33;
         5'd6:    b = 8'h35;
         5'd7:    b = 8'h30;
         5'd8:    b = 8'h61;
         5'd9:    b = 8'h65;
         5'd10:   b = 8'h30;
         5'd11:   b = 8'h34;
         5'd12:   b = 8'h61;
         5'd13:   b = 8'h62;
         5'd14:   b = 8'h38;
         5'd15:   b = 8'h37;
         5'd16:   b = 8'h36;
         5'd17:   b = 8'h33;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic [7:0] sig_udp_byte(logic [3:0] i);
      logic [7:0] b;
      case (i)
         4'd0:    b = 8'h73;
         4'd1:    b = 8'h74;
         4'd2:    b = 8'h61;
         4'd3:    b = 8'h72;
         4'd4:    b = 8'h74;
         4'd5:    b = 8'h5f;
         4'd6:    b = 8'h65;
         4'd7:    b = 8'h76;
         4'd8:    b = 8'h65;
         4'd9:    b = 8'h6e;
         4'd10:   b = 8'h74;
         4'd11:   b = 8'h31;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

@@ hdl/gfsc_queue.sv @@
module gfsc_queue
   import gfsc_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = store_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hdl/gfsc_front.sv @@
module gfsc_front
   import gfsc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type req,
   output logic    cmd_push,
   output cmd_type cmd
);

   logic [15:0] pos_ff, pos_in;
   logic        hdr_ok_ff, hdr_ok_in;
   scan_type    phase_ff, phase_in;
   logic [4:0]  sig_idx_ff, sig_idx_in;
   logic        sig_ok_ff, sig_ok_in;
   logic [15:0] udp_len_ff, udp_len_in;
   logic        start_ok_ff, start_ok_in;
   logic        port_ok_ff, port_ok_in;

   logic [15:0] p;
   logic [15:0] scan_start;
   logic        in_window;
   logic [15:0] udp_off;
   logic        count_bad, tcp_found, udp_bad;

   always_comb begin
      // Restart the per-packet evidence on a first byte.
      p           = req.first_of_packet ? '0 : pos_ff;
      hdr_ok_in   = req.first_of_packet ? 1'b1 : hdr_ok_ff;
      phase_in    = req.first_of_packet ? SCAN_SEEK : phase_ff;
      sig_idx_in  = req.first_of_packet ? '0 : sig_idx_ff;
      sig_ok_in   = req.first_of_packet ? 1'b1 : sig_ok_ff;
      udp_len_in  = req.first_of_packet ? '0 : udp_len_ff;
      start_ok_in = req.first_of_packet ? 1'b1 : start_ok_ff;
      port_ok_in  = req.first_of_packet ? 1'b1 : port_ok_ff;

      if (p < HEAD_LEN && head_checked(p[4:0]) && req.data_byte != head_byte(p[4:0])) begin
         hdr_ok_in = 1'b0;
      end
      if (p == '0 && req.data_byte != SIG_LEAD_BYTE) begin
         sig_ok_in = 1'b0;
      end

      scan_start = req.packet_length - TCP_SCAN_BACK;
      in_window  = ({1'b0, p} >= {1'b0, scan_start}) &&
                   ({1'b0, p} < ({1'b0, scan_start} + TCP_SCAN_SPAN));
      if (req.packet_length > TCP_SCAN_MIN_LEN) begin
         case (phase_in)
            SCAN_GAP: begin
               phase_in   = SCAN_COMPARE;
               sig_idx_in = '0;
            end
            SCAN_COMPARE: begin
               if (sig_idx_in < SIG_TCP_LEN && req.data_byte != sig_tcp_byte(sig_idx_in)) begin
                  sig_ok_in = 1'b0;
               end
               sig_idx_in = sig_idx_in + 1'b1;
               if (sig_idx_in >= SIG_TCP_LEN) begin
                  phase_in = SCAN_DONE;
               end
            end
            SCAN_SEEK: begin
               if (in_window && req.data_byte != 8'h00) begin
                  phase_in = SCAN_GAP;
               end
            end
            default: ;
         endcase
      end

      if (p == UDP_LEN_HI_POS || p == UDP_LEN_LO_POS) begin
         udp_len_in = {udp_len_in[7:0], req.data_byte};
      end
      udp_off = p - UDP_START_POS;
      if (p >= UDP_START_POS && p < UDP_START_END &&
          req.data_byte != sig_udp_byte(udp_off[3:0])) begin
         start_ok_in = 1'b0;
      end
      if ((p == UDP_PORT_HI_POS && req.data_byte != UDP_PORT_HI) ||
          (p == UDP_PORT_LO_POS && req.data_byte != UDP_PORT_LO)) begin
         port_ok_in = 1'b0;
      end

      pos_in = (p == 16'hffff) ? p : p + 1'b1;

      // Classify from the evidence including this byte.
      count_bad = (req.packet_length != '0) && (({1'b0, p} + 17'd1) != {1'b0, req.packet_length});
      tcp_found = (req.packet_length == TCP_FIXED_LEN && hdr_ok_in) ||
                  (req.packet_length > TCP_SCAN_MIN_LEN && sig_ok_in && phase_in == SCAN_DONE);
      udp_bad   = (req.packet_length <= UDP_MIN_LEN) || (udp_len_in != req.packet_length);

      cmd.flow_slot = req.flow_slot;
      cmd.clear     = req.first_of_packet && req.new_flow;
      cmd.classify  = req.last_of_packet;
      cmd.start_ok  = start_ok_in;
      cmd.port_ok   = port_ok_in;
      if (count_bad) begin
         cmd.cls = CLS_EXCLUDE;
      end else if (!req.is_udp) begin
         cmd.cls = tcp_found ? CLS_FOUND : CLS_EXCLUDE;
      end else begin
         cmd.cls = udp_bad ? CLS_EXCLUDE : CLS_UDP;
      end
      cmd_push = accept && (cmd.clear || cmd.classify);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         hdr_ok_ff   <= 1'b1;
         phase_ff    <= SCAN_SEEK;
         sig_idx_ff  <= '0;
         sig_ok_ff   <= 1'b1;
         udp_len_ff  <= '0;
         start_ok_ff <= 1'b1;
         port_ok_ff  <= 1'b1;
      end else if (accept) begin
         if (req.last_of_packet) begin
            pos_ff      <= '0;
            hdr_ok_ff   <= 1'b1;
            phase_ff    <= SCAN_SEEK;
            sig_idx_ff  <= '0;
            sig_ok_ff   <= 1'b1;
            udp_len_ff  <= '0;
            start_ok_ff <= 1'b1;
            port_ok_ff  <= 1'b1;
         end else begin
            pos_ff      <= pos_in;
            hdr_ok_ff   <= hdr_ok_in;
            phase_ff    <= phase_in;
            sig_idx_ff  <= sig_idx_in;
            sig_ok_ff   <= sig_ok_in;
            udp_len_ff  <= udp_len_in;
            start_ok_ff <= start_ok_in;
            port_ok_ff  <= port_ok_in;
         end
      end
   end

endmodule

@@ hdl/gfsc_back.sv @@
module gfsc_back
   import gfsc_pkg::*;
#(
   parameter int FLOW_SLOTS = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_empty,
   input  cmd_type cmd_head,
   output logic    cmd_pop,
   input  logic    rsp_full,
   output logic    rsp_push,
   output rsp_type rsp,
   output logic    clear_busy
);

   localparam int SLOT_W = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(FLOW_SLOTS - 1);

   stage_type         stage_mem [FLOW_SLOTS];
   stage_type         rd_stage_ff;
   logic              s2_valid_ff, s2_valid_in;
   cmd_type           s2_cmd_ff;
   logic [SLOT_W-1:0] s2_idx_ff;
   logic              fwd_hit_ff;
   stage_type         fwd_stage_ff;
   logic              busy_ff;
   logic [SLOT_W-1:0] clr_idx_ff;

   logic [SLOT_W-1:0] head_idx;
   logic              s2_fire, s2_we;
   stage_type         cur_stage, new_stage;

   // Wrap the flow index into the store.
   generate
      if (FLOW_SLOTS < 256) begin : g_wrap
         always_comb begin
            logic [15:0] rem;
            rem = 16'(cmd_head.flow_slot);
            for (int i = 7; i >= 0; i--) begin
               if (rem >= (16'(FLOW_SLOTS) << i)) begin
                  rem = rem - (16'(FLOW_SLOTS) << i);
               end
            end
            head_idx = rem[SLOT_W-1:0];
         end
      end else begin : g_direct
         assign head_idx = SLOT_W'(cmd_head.flow_slot);
      end
   endgenerate

   assign clear_busy = busy_ff;
   assign s2_fire    = s2_valid_ff && (!s2_cmd_ff.classify || !rsp_full);
   assign cmd_pop    = !cmd_empty && !busy_ff && (!s2_valid_ff || s2_fire);
   assign s2_we      = s2_fire && (s2_cmd_ff.clear || s2_cmd_ff.classify);
   assign s2_valid_in = cmd_pop || (s2_valid_ff && !s2_fire);

   always_comb begin
      cur_stage = fwd_hit_ff ? fwd_stage_ff : rd_stage_ff;
      if (s2_cmd_ff.clear) begin
         cur_stage = STAGE_UDP0;
      end
      new_stage = cur_stage;
      if (s2_cmd_ff.classify && (cur_stage == STAGE_UDP0 || cur_stage == STAGE_UDP1)) begin
         unique case (s2_cmd_ff.cls)
            CLS_FOUND:   new_stage = STAGE_FOUND;
            CLS_UDP: begin
               if (cur_stage == STAGE_UDP0) begin
                  new_stage = s2_cmd_ff.start_ok ? STAGE_UDP1 : STAGE_UDP0;
               end else begin
                  new_stage = s2_cmd_ff.port_ok ? STAGE_FOUND : STAGE_EXCLUDED;
               end
            end
            default:     new_stage = STAGE_EXCLUDED;
         endcase
      end
      rsp.flow_slot = s2_cmd_ff.flow_slot;
      unique case (new_stage)
         STAGE_FOUND:    rsp.verdict = VERDICT_FOUND;
         STAGE_EXCLUDED: rsp.verdict = VERDICT_EXCLUDED;
         default:        rsp.verdict = VERDICT_UNDECIDED;
      endcase
      rsp_push = s2_fire && s2_cmd_ff.classify;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         clr_idx_ff  <= '0;
         s2_valid_ff <= 1'b0;
         fwd_hit_ff  <= 1'b0;
      end else begin
         if (busy_ff) begin
            clr_idx_ff <= clr_idx_ff + 1'b1;
            if (clr_idx_ff == LAST_SLOT) begin
               busy_ff <= 1'b0;
            end
         end
         s2_valid_ff <= s2_valid_in;
         if (cmd_pop) begin
            fwd_hit_ff <= s2_we && (s2_idx_ff == head_idx);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         s2_cmd_ff    <= cmd_head;
         s2_idx_ff    <= head_idx;
         fwd_stage_ff <= new_stage;
      end
   end

   // Stage store: one write port (clearing pass or update), one registered read.
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         stage_mem[clr_idx_ff] <= STAGE_UDP0;
      end else if (s2_we) begin
         stage_mem[s2_idx_ff] <= new_stage;
      end
      if (cmd_pop) begin
         rd_stage_ff <= stage_mem[head_idx];
      end
   end

endmodule

@@ hdl/game_flow_signature_classifier.sv @@
// Game flow signature classifier.
// Input channel (req_*): one payload byte per item with its flow slot, protocol,
// payload length and first/last/new-flow marks. An item is taken on a rising
// edge with req_push high and req_full low, one byte per cycle while it stays low.
// Result channel (rsp_*): one item per packet, issued for the packet's last
// byte, holding the flow slot and the verdict (undecided, found, excluded).
// The oldest result sits on rsp_* while rsp_empty is low; rsp_pop takes it.
// A last byte's result passes the work queue, the back part's read stage and
// the result queue on its way to the result ports. The front part tracks
// per-packet evidence and queues clear/classify work; the back part does a
// read-modify-write on the per-flow stage store, one work item per cycle while
// the result queue has room, forwarding a stage written in the previous cycle to
// the same flow. Reset (synchronous, active high) empties both queues and starts
// a clearing pass over every slot of the stage store; req_full stays high until
// it is done. When the receiver stalls, results collect in the result queue,
// then in the work queue, and req_full rises once that queue fills; nothing
// is dropped.
module game_flow_signature_classifier
   import gfsc_pkg::*;
#(
   parameter int FLOW_SLOTS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  req_flow_slot,
   input  logic        req_is_udp,
   input  logic [15:0] req_packet_length,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_of_packet,
   input  logic        req_last_of_packet,
   input  logic        req_new_flow,
   input  logic        req_push,
   output logic        req_full,
   output logic [7:0]  rsp_flow_slot_out,
   output logic [1:0]  rsp_verdict,
   output logic        rsp_empty,
   input  logic        rsp_pop
);

`include "assert_macros.svh"

   req_type req;
   logic    accept;
   logic    cmd_push;
   cmd_type cmd_in, cmd_head;
   logic    cmdq_full, cmdq_empty, cmd_pop;
   logic    rspq_full, rsp_push;
   rsp_type rsp_in, rsp_head;
   logic    clear_busy;

   // Pack the input ports in field order.
   assign req = {req_flow_slot, req_is_udp, req_packet_length, req_data_byte,
                 req_first_of_packet, req_last_of_packet, req_new_flow};

   // Hold the input off while the work queue is full or the store is clearing.
   assign req_full = cmdq_full || clear_busy;
   assign accept   = req_push && !req_full;

   gfsc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req),
      .cmd_push (cmd_push),
      .cmd      (cmd_in)
   );

   gfsc_queue #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (CMDQ_DEPTH)
   ) u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (cmdq_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_head),
      .empty     (cmdq_empty)
   );

   gfsc_back #(
      .FLOW_SLOTS (FLOW_SLOTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_empty  (cmdq_empty),
      .cmd_head   (cmd_head),
      .cmd_pop    (cmd_pop),
      .rsp_full   (rspq_full),
      .rsp_push   (rsp_push),
      .rsp        (rsp_in),
      .clear_busy (clear_busy)
   );

   gfsc_queue #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSPQ_DEPTH)
   ) u_rspq (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in),
      .full      (rspq_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_head),
      .empty     (rsp_empty)
   );

   assign rsp_flow_slot_out = rsp_head.flow_slot;
   assign rsp_verdict       = rsp_head.verdict;

   `ASSERT_CLK_RST(a_last_queues_work, clock, reset, (accept && req_last_of_packet) |-> cmd_push, "last byte did not queue a classify")
   `ASSERT_CLK_RST(a_no_overflow, clock, reset, cmd_push |-> !cmdq_full, "work queue overflow")
   `ASSERT_CLK_RST(a_verdict_code, clock, reset, !rsp_empty |-> (rsp_verdict != 2'd3), "bad verdict code")
   `ASSERT_CLK_RST(a_clear_quiet, clock, reset, clear_busy |-> (rsp_empty && cmdq_empty), "work seen during clearing pass")

endmodule
